FILE: design/epr_pkg.sv
// ----------------------------------------------------------------------------
// epr_pkg
// Shared types, constants, sine table and microprogram of the Euler-angle
// point rotator.
// ----------------------------------------------------------------------------
package epr_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int ANGLE_STEPS    = 360;
  localparam int QUARTER        = ANGLE_STEPS / 4;
  localparam int HALF_TURN      = ANGLE_STEPS / 2;
  localparam int THREE_QUARTER  = 3 * ANGLE_STEPS / 4;
  localparam int FRAC           = 14;
  localparam int HALF_Q         = 1 << (FRAC - 1);
  localparam int TRIG_W         = FRAC + 2;
  localparam int ANGLE_W        = 9;
  localparam int START_W        = 16;
  localparam int OFS_BITS       = 18;
  localparam int NUM_AXES       = 3;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 16;
  localparam int QIDX_W         = 7;
  localparam int PC_W           = 5;

  // microprogram addresses
  localparam logic [PC_W-1:0] PC_IDLE  = PC_W'(0);
  localparam logic [PC_W-1:0] PC_ROT_Z = PC_W'(1);
  localparam logic [PC_W-1:0] PC_ROT_Y = PC_W'(7);
  localparam logic [PC_W-1:0] PC_ROT_X = PC_W'(13);
  localparam logic [PC_W-1:0] PC_FIN   = PC_W'(19);
  localparam logic [PC_W-1:0] PC_SUM   = PC_W'(20);
  localparam logic [PC_W-1:0] PC_DLV   = PC_W'(21);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ANGLE_X,
    REG_ANGLE_Y,
    REG_ANGLE_Z,
    REG_START_X,
    REG_START_Y,
    REG_START_Z
  } cfg_reg_t;

  typedef enum logic [1:0] {
    AX_X,
    AX_Y,
    AX_Z
  } axis_t;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_IN,
    COND_OUT
  } cond_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef enum logic [2:0] {
    PH_MUL_CA,
    PH_MUL_SB,
    PH_MUL_SA,
    PH_MUL_CB,
    PH_ADD,
    PH_WRITE
  } rphase_t;

  typedef struct packed {
    cond_t           cond;
    logic            jmp;
    logic [PC_W-1:0] target;
    axis_t           ang;
    logic            use_sin;
    axis_t           src;
    acc_op_t         acc_op;
    logic            tmp_wr;
    logic            pair_wr;
    axis_t           dst_a;
    axis_t           dst_b;
    logic            fin;
    logic            sum;
    logic            dlv;
  } uword_t;

  // sin of 0..90 degrees in Q2.14
  localparam logic [FRAC:0] QSINE [0:QUARTER] = '{
    15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,
    15'd1428,  15'd1713,  15'd1997,  15'd2280,  15'd2563,
    15'd2845,  15'd3126,  15'd3406,  15'd3686,  15'd3964,
    15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,
    15'd5604,  15'd5872,  15'd6138,  15'd6402,  15'd6664,
    15'd6924,  15'd7182,  15'd7438,  15'd7692,  15'd7943,
    15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
    15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311,
    15'd10531, 15'd10749, 15'd10963, 15'd11174, 15'd11381,
    15'd11585, 15'd11786, 15'd11982, 15'd12176, 15'd12365,
    15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
    15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044,
    15'd14189, 15'd14330, 15'd14466, 15'd14598, 15'd14726,
    15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
    15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749,
    15'd15826, 15'd15897, 15'd15964, 15'd16026, 15'd16083,
    15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
    15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382,
    15'd16384
  };

  // argument below two full turns (720 degrees); one full turn is folded off
  function automatic logic signed [TRIG_W-1:0] sine_q(input logic [ANGLE_W:0] a);
    logic [ANGLE_W:0]        v;
    logic [QIDX_W-1:0]       idx;
    logic                    neg;
    logic signed [TRIG_W-1:0] mag;
    v = (a >= ANGLE_STEPS) ? a - (ANGLE_W+1)'(ANGLE_STEPS) : a;
    neg = 1'b0;
    if (v <= QUARTER) begin
      idx = QIDX_W'(v);
    end else if (v <= HALF_TURN) begin
      idx = QIDX_W'((ANGLE_W+1)'(HALF_TURN) - v);
    end else if (v <= THREE_QUARTER) begin
      idx = QIDX_W'(v - (ANGLE_W+1)'(HALF_TURN));
      neg = 1'b1;
    end else begin
      idx = QIDX_W'((ANGLE_W+1)'(ANGLE_STEPS) - v);
      neg = 1'b1;
    end
    mag = $signed({1'b0, QSINE[idx]});
    return neg ? -mag : mag;
  endfunction

  // one step of an elemental rotation of the pair (a, b)
  function automatic uword_t rot_step(input rphase_t ph, input axis_t a, input axis_t b,
                                      input axis_t ang);
    uword_t w;
    w       = '0;
    w.ang   = ang;
    w.dst_a = a;
    w.dst_b = b;
    case (ph)
      PH_MUL_CA: begin
        w.src = a;
      end
      PH_MUL_SB: begin
        w.acc_op  = ACC_LOAD;
        w.use_sin = 1'b1;
        w.src     = b;
      end
      PH_MUL_SA: begin
        w.acc_op  = ACC_SUB;
        w.use_sin = 1'b1;
        w.src     = a;
      end
      PH_MUL_CB: begin
        w.tmp_wr = 1'b1;
        w.acc_op = ACC_LOAD;
        w.src    = b;
      end
      PH_ADD: begin
        w.acc_op = ACC_ADD;
      end
      PH_WRITE: begin
        w.pair_wr = 1'b1;
      end
      default: begin
        w.pair_wr = 1'b0;
      end
    endcase
    return w;
  endfunction

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '0;
    unique case (pc)
      PC_IDLE:              w.cond = COND_IN;
      PC_ROT_Z:             w = rot_step(PH_MUL_CA, AX_X, AX_Y, AX_Z);
      PC_ROT_Z + PC_W'(1):  w = rot_step(PH_MUL_SB, AX_X, AX_Y, AX_Z);
      PC_ROT_Z + PC_W'(2):  w = rot_step(PH_MUL_SA, AX_X, AX_Y, AX_Z);
      PC_ROT_Z + PC_W'(3):  w = rot_step(PH_MUL_CB, AX_X, AX_Y, AX_Z);
      PC_ROT_Z + PC_W'(4):  w = rot_step(PH_ADD,    AX_X, AX_Y, AX_Z);
      PC_ROT_Z + PC_W'(5):  w = rot_step(PH_WRITE,  AX_X, AX_Y, AX_Z);
      PC_ROT_Y:             w = rot_step(PH_MUL_CA, AX_Z, AX_X, AX_Y);
      PC_ROT_Y + PC_W'(1):  w = rot_step(PH_MUL_SB, AX_Z, AX_X, AX_Y);
      PC_ROT_Y + PC_W'(2):  w = rot_step(PH_MUL_SA, AX_Z, AX_X, AX_Y);
      PC_ROT_Y + PC_W'(3):  w = rot_step(PH_MUL_CB, AX_Z, AX_X, AX_Y);
      PC_ROT_Y + PC_W'(4):  w = rot_step(PH_ADD,    AX_Z, AX_X, AX_Y);
      PC_ROT_Y + PC_W'(5):  w = rot_step(PH_WRITE,  AX_Z, AX_X, AX_Y);
      PC_ROT_X:             w = rot_step(PH_MUL_CA, AX_Y, AX_Z, AX_X);
      PC_ROT_X + PC_W'(1):  w = rot_step(PH_MUL_SB, AX_Y, AX_Z, AX_X);
      PC_ROT_X + PC_W'(2):  w = rot_step(PH_MUL_SA, AX_Y, AX_Z, AX_X);
      PC_ROT_X + PC_W'(3):  w = rot_step(PH_MUL_CB, AX_Y, AX_Z, AX_X);
      PC_ROT_X + PC_W'(4):  w = rot_step(PH_ADD,    AX_Y, AX_Z, AX_X);
      PC_ROT_X + PC_W'(5):  w = rot_step(PH_WRITE,  AX_Y, AX_Z, AX_X);
      PC_FIN:               w.fin = 1'b1;
      PC_SUM:               w.sum = 1'b1;
      PC_DLV: begin
        w.cond   = COND_OUT;
        w.jmp    = 1'b1;
        w.target = PC_IDLE;
        w.dlv    = 1'b1;
      end
      default: begin
        w.jmp    = 1'b1;
        w.target = PC_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: design/epr_ifs.sv
// ----------------------------------------------------------------------------
// epr channel interfaces
// Point input, result output and register write channels, valid/ready.
// ----------------------------------------------------------------------------
interface epr_in_if import epr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] in_x;
  logic signed [COORD_BITS-1:0] in_y;
  logic signed [COORD_BITS-1:0] in_z;

  modport source (output valid, output in_x, output in_y, output in_z, input ready);
  modport sink   (input valid, input in_x, input in_y, input in_z, output ready);
endinterface

interface epr_out_if import epr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] out_x;
  logic signed [COORD_BITS-1:0] out_y;
  logic signed [COORD_BITS-1:0] out_z;
  logic signed [OFS_BITS-1:0]   offset_x;
  logic signed [OFS_BITS-1:0]   offset_y;
  logic signed [OFS_BITS-1:0]   offset_z;

  modport source (output valid, output out_x, output out_y, output out_z,
                  output offset_x, output offset_y, output offset_z, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z,
                  input offset_x, input offset_y, input offset_z, output ready);
endinterface

interface epr_cfg_if import epr_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

FILE: design/euler_point_rotation_top.sv
// ----------------------------------------------------------------------------
// euler_point_rotation_top
// Rotates integer 3D points about Z, Y then X by whole-degree angles and
// tracks a running per-axis maximum of -(rotated + start).
// ----------------------------------------------------------------------------
// A point is taken when the sequencer sits in its idle step and leaves as one
// result at the end of the microprogram; no new point is taken before the last
// one has been handed to the output register. The microprogram holds three
// elemental rotations of six steps each on a single shared Q2.14 x coordinate
// multiplier, then one step each to round, add the start position and update
// the maxima. A finished result waits in an output register, so the next
// point is taken while it is still pending; the last step holds only if that
// register is still full. Register writes are taken at any time with ready
// always high and must only be issued while no point is in flight.
// ----------------------------------------------------------------------------
module euler_point_rotation_top import epr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  epr_in_if.sink    in_pt,
  epr_out_if.source out_pt,
  epr_cfg_if.sink   cfg_wr
);

  localparam int QW   = COORD_BITS + FRAC + 2;
  localparam int PW   = QW + TRIG_W;
  localparam int AW   = PW + 1;
  localparam int FW   = QW + 1 - FRAC;
  localparam int SUMW = ((COORD_BITS > START_W) ? COORD_BITS : START_W) + 1;
  localparam int NW   = (SUMW + 1 > OFS_BITS) ? SUMW + 1 : OFS_BITS;

  localparam logic signed [FW-1:0] FIN_HI = {{(FW-COORD_BITS+1){1'b0}},
                                             {(COORD_BITS-1){1'b1}}};
  localparam logic signed [FW-1:0] FIN_LO = {{(FW-COORD_BITS+1){1'b1}},
                                             {(COORD_BITS-1){1'b0}}};
  localparam logic signed [NW-1:0] OFS_HI = {{(NW-OFS_BITS+1){1'b0}},
                                             {(OFS_BITS-1){1'b1}}};
  localparam logic signed [NW-1:0] OFS_LO = {{(NW-OFS_BITS+1){1'b1}},
                                             {(OFS_BITS-1){1'b0}}};

  logic        [ANGLE_W-1:0]    angle_r [NUM_AXES];
  logic signed [START_W-1:0]    start_r [NUM_AXES];
  logic signed [TRIG_W-1:0]     sin_r   [NUM_AXES];
  logic signed [TRIG_W-1:0]     cos_r   [NUM_AXES];
  logic signed [TRIG_W-1:0]     sin_nxt [NUM_AXES];
  logic signed [TRIG_W-1:0]     cos_nxt [NUM_AXES];

  logic        [PC_W-1:0]       pc_r, pc_nxt;
  uword_t                       uw;
  logic                         advance;
  logic                         take;
  logic                         slot_free;
  logic                         deliver;

  logic signed [QW-1:0]         q_r     [NUM_AXES];
  logic signed [QW-1:0]         tmp_r;
  logic signed [TRIG_W-1:0]     coef;
  logic signed [QW-1:0]         opnd;
  logic signed [PW-1:0]         prod_r;
  logic signed [AW-1:0]         acc_r, acc_nxt;
  logic signed [AW-1:0]         acc_h;
  logic signed [QW-1:0]         rnd;

  logic signed [QW:0]           fin_t   [NUM_AXES];
  logic signed [FW-1:0]         fin_fl  [NUM_AXES];
  logic signed [FW-1:0]         fin_tr  [NUM_AXES];
  logic signed [COORD_BITS-1:0] res_nxt [NUM_AXES];
  logic signed [COORD_BITS-1:0] res_r   [NUM_AXES];
  logic signed [SUMW-1:0]       sum_r   [NUM_AXES];
  logic signed [NW-1:0]         neg     [NUM_AXES];
  logic signed [OFS_BITS-1:0]   neg_sat [NUM_AXES];
  logic signed [OFS_BITS-1:0]   mx_r    [NUM_AXES];
  logic signed [OFS_BITS-1:0]   mx_nxt  [NUM_AXES];

  logic signed [COORD_BITS-1:0] ox_r    [NUM_AXES];
  logic signed [OFS_BITS-1:0]   ofs_r   [NUM_AXES];
  logic                         out_valid_r;

  // register writes
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        angle_r[i] <= '0;
        start_r[i] <= '0;
      end
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.addr)
        REG_ANGLE_X: angle_r[AX_X] <= cfg_wr.data[ANGLE_W-1:0];
        REG_ANGLE_Y: angle_r[AX_Y] <= cfg_wr.data[ANGLE_W-1:0];
        REG_ANGLE_Z: angle_r[AX_Z] <= cfg_wr.data[ANGLE_W-1:0];
        REG_START_X: start_r[AX_X] <= cfg_wr.data[START_W-1:0];
        REG_START_Y: start_r[AX_Y] <= cfg_wr.data[START_W-1:0];
        REG_START_Z: start_r[AX_Z] <= cfg_wr.data[START_W-1:0];
        default: ;
      endcase
    end
  end

  // sine and cosine per axis, refreshed every cycle from the angle registers
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      sin_nxt[i] = sine_q({1'b0, angle_r[i]});
      cos_nxt[i] = sine_q(((angle_r[i] >= ANGLE_STEPS) ?
                           {1'b0, angle_r[i]} - (ANGLE_W+1)'(ANGLE_STEPS) :
                           {1'b0, angle_r[i]}) + (ANGLE_W+1)'(QUARTER));
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_AXES; i++) begin
      sin_r[i] <= sin_nxt[i];
      cos_r[i] <= cos_nxt[i];
    end
  end

  // sequencer
  assign uw        = ucode(pc_r);
  assign slot_free = !out_valid_r || out_pt.ready;
  assign take      = (uw.cond == COND_IN) && in_pt.valid;
  assign deliver   = uw.dlv && slot_free;

  always_comb begin
    unique case (uw.cond)
      COND_IN:  advance = in_pt.valid;
      COND_OUT: advance = slot_free;
      default:  advance = 1'b1;
    endcase
    if (!advance) begin
      pc_nxt = pc_r;
    end else if (uw.jmp) begin
      pc_nxt = uw.target;
    end else begin
      pc_nxt = pc_r + PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign in_pt.ready = (uw.cond == COND_IN);

  // shared multiplier and accumulator
  assign coef  = uw.use_sin ? sin_r[uw.ang] : cos_r[uw.ang];
  assign opnd  = q_r[uw.src];
  assign acc_h = acc_r + AW'(HALF_Q);
  assign rnd   = acc_h[FRAC +: QW];

  always_comb begin
    case (uw.acc_op)
      ACC_LOAD: acc_nxt = AW'(prod_r);
      ACC_ADD:  acc_nxt = acc_r + AW'(prod_r);
      ACC_SUB:  acc_nxt = acc_r - AW'(prod_r);
      default:  acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= coef * opnd;
    acc_r  <= acc_nxt;
    if (uw.tmp_wr) begin
      tmp_r <= rnd;
    end
    if (take) begin
      q_r[AX_X] <= QW'(in_pt.in_x) <<< FRAC;
      q_r[AX_Y] <= QW'(in_pt.in_y) <<< FRAC;
      q_r[AX_Z] <= QW'(in_pt.in_z) <<< FRAC;
    end else if (uw.pair_wr) begin
      q_r[uw.dst_a] <= tmp_r;
      q_r[uw.dst_b] <= rnd;
    end
  end

  // final rounding: add one half, truncate toward zero, saturate
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      fin_t[i]  = (QW+1)'(q_r[i]) + (QW+1)'(HALF_Q);
      fin_fl[i] = fin_t[i][QW:FRAC];
      fin_tr[i] = (fin_t[i][QW] && (fin_t[i][FRAC-1:0] != '0)) ?
                  fin_fl[i] + FW'(1) : fin_fl[i];
      if (fin_tr[i] > FIN_HI) begin
        res_nxt[i] = FIN_HI[COORD_BITS-1:0];
      end else if (fin_tr[i] < FIN_LO) begin
        res_nxt[i] = FIN_LO[COORD_BITS-1:0];
      end else begin
        res_nxt[i] = fin_tr[i][COORD_BITS-1:0];
      end
    end
  end

  // offset: -(coord + start), saturated, then running maximum
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      neg[i] = -NW'(sum_r[i]);
      if (neg[i] > OFS_HI) begin
        neg_sat[i] = OFS_HI[OFS_BITS-1:0];
      end else if (neg[i] < OFS_LO) begin
        neg_sat[i] = OFS_LO[OFS_BITS-1:0];
      end else begin
        neg_sat[i] = neg[i][OFS_BITS-1:0];
      end
      mx_nxt[i] = (neg_sat[i] > mx_r[i]) ? neg_sat[i] : mx_r[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_AXES; i++) begin
      if (uw.fin) begin
        res_r[i] <= res_nxt[i];
      end
      if (uw.sum) begin
        sum_r[i] <= SUMW'(res_r[i]) + SUMW'(start_r[i]);
      end
      if (deliver) begin
        ox_r[i]  <= res_r[i];
        ofs_r[i] <= mx_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        mx_r[i] <= '0;
      end
    end else if (deliver) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        mx_r[i] <= mx_nxt[i];
      end
    end
  end

  // output register, freed by a transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (deliver) begin
      out_valid_r <= 1'b1;
    end else if (out_pt.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_pt.valid    = out_valid_r;
  assign out_pt.out_x    = ox_r[AX_X];
  assign out_pt.out_y    = ox_r[AX_Y];
  assign out_pt.out_z    = ox_r[AX_Z];
  assign out_pt.offset_x = ofs_r[AX_X];
  assign out_pt.offset_y = ofs_r[AX_Y];
  assign out_pt.offset_z = ofs_r[AX_Z];

  // assertions
  a_take_starts_rot: assert property (@(posedge clk) disable iff (!rst_n)
    (in_pt.valid && in_pt.ready) |=> (pc_r == PC_ROT_Z))
    else $error("point transfer did not start the rotation program");

  a_pc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= PC_DLV)
    else $error("sequencer left the microprogram");

  a_result_from_dlv: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(pc_r) == PC_DLV))
    else $error("result raised outside the delivery step");

  a_max_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> ((mx_r[AX_X] >= $past(mx_r[AX_X])) &&
              (mx_r[AX_Y] >= $past(mx_r[AX_Y])) &&
              (mx_r[AX_Z] >= $past(mx_r[AX_Z]))))
    else $error("running offset maximum decreased");

endmodule

FILE: sim/epr_rotation_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// epr_rotation_checker
// Watches the point, result and register channels of the Euler-angle point
// rotator. It tracks the register file and the running offset maxima itself,
// works out every rotated point as it is taken and compares each result
// transfer with the oldest point still owed, field by field.
// ----------------------------------------------------------------------------
module epr_rotation_checker import epr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_x,
  input  logic signed [COORD_BITS-1:0] in_y,
  input  logic signed [COORD_BITS-1:0] in_z,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic signed [COORD_BITS-1:0] out_x,
  input  logic signed [COORD_BITS-1:0] out_y,
  input  logic signed [COORD_BITS-1:0] out_z,
  input  logic signed [OFS_BITS-1:0]   offset_x,
  input  logic signed [OFS_BITS-1:0]   offset_y,
  input  logic signed [OFS_BITS-1:0]   offset_z,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  output int                           outstanding,
  output int                           mismatches
);

  localparam int     FBITS        = 14;
  localparam longint Q_ONE        = 16384;
  localparam longint Q_HALF       = 8192;
  localparam int     DEGREES      = 360;
  localparam longint COORD_HI     = (longint'(1) << (COORD_BITS - 1)) - 1;
  localparam longint COORD_LO     = -COORD_HI - 1;
  localparam longint OFS_HI       = (longint'(1) << (OFS_BITS - 1)) - 1;
  localparam longint OFS_LO       = -OFS_HI - 1;
  localparam int     REPORT_LIMIT = 40;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
    logic signed [OFS_BITS-1:0]   ox;
    logic signed [OFS_BITS-1:0]   oy;
    logic signed [OFS_BITS-1:0]   oz;
  } rotated_point_t;

  // sine of 0..90 degrees, q2.14
  int quarter_wave [0:90] = '{
    0, 286, 572, 857, 1143, 1428, 1713, 1997, 2280, 2563,
    2845, 3126, 3406, 3686, 3964, 4240, 4516, 4790, 5063, 5334,
    5604, 5872, 6138, 6402, 6664, 6924, 7182, 7438, 7692, 7943,
    8192, 8438, 8682, 8923, 9162, 9397, 9630, 9860, 10087, 10311,
    10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
    12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
    14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
    15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
    16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
    16384
  };

  logic [ANGLE_W-1:0]        ang_x, ang_y, ang_z;
  logic signed [START_W-1:0] start_x, start_y, start_z;
  longint                    peak_x, peak_y, peak_z;
  rotated_point_t            expected_points [$];

  function automatic longint sine_q14(input int unsigned deg);
    int unsigned a;
    a = deg % DEGREES;
    if (a <= 90) return longint'(quarter_wave[a]);
    else if (a <= 180) return longint'(quarter_wave[180 - a]);
    else if (a <= 270) return -longint'(quarter_wave[a - 180]);
    else return -longint'(quarter_wave[360 - a]);
  endfunction

  function automatic longint cosine_q14(input int unsigned deg);
    return sine_q14(deg % DEGREES + 90);
  endfunction

  // exact product sum, half added and rounded back to q.14 with the floor
  function automatic longint mix_q14(input longint p, input longint q,
                                     input longint kp, input longint kq);
    return (kp * p + kq * q + Q_HALF) >>> FBITS;
  endfunction

  // half added, truncated toward zero, saturated
  function automatic logic signed [COORD_BITS-1:0] round_coord(input longint q);
    longint t;
    longint r;
    t = q + Q_HALF;
    r = (t >= 0) ? (t >>> FBITS) : -((-t) >>> FBITS);
    if (r > COORD_HI) r = COORD_HI;
    if (r < COORD_LO) r = COORD_LO;
    return r[COORD_BITS-1:0];
  endfunction

  function automatic longint neg_offset(input logic signed [COORD_BITS-1:0] c,
                                        input logic signed [START_W-1:0] s);
    longint n;
    n = -(longint'(c) + longint'(s));
    if (n > OFS_HI) n = OFS_HI;
    if (n < OFS_LO) n = OFS_LO;
    return n;
  endfunction

  // rotates about z, then y, then x and moves the offset maxima on
  function automatic rotated_point_t rotate_point(input logic signed [COORD_BITS-1:0] px,
                                                  input logic signed [COORD_BITS-1:0] py,
                                                  input logic signed [COORD_BITS-1:0] pz);
    longint         x, y, z, c, s, t;
    rotated_point_t r;
    x = longint'(px) * Q_ONE;
    y = longint'(py) * Q_ONE;
    z = longint'(pz) * Q_ONE;
    c = cosine_q14(ang_z);
    s = sine_q14(ang_z);
    t = mix_q14(x, y, c, -s);
    y = mix_q14(x, y, s, c);
    x = t;
    c = cosine_q14(ang_y);
    s = sine_q14(ang_y);
    t = mix_q14(z, x, c, -s);
    x = mix_q14(z, x, s, c);
    z = t;
    c = cosine_q14(ang_x);
    s = sine_q14(ang_x);
    t = mix_q14(y, z, c, -s);
    z = mix_q14(y, z, s, c);
    y = t;
    r.x = round_coord(x);
    r.y = round_coord(y);
    r.z = round_coord(z);
    t = neg_offset(r.x, start_x);
    if (t > peak_x) peak_x = t;
    t = neg_offset(r.y, start_y);
    if (t > peak_y) peak_y = t;
    t = neg_offset(r.z, start_z);
    if (t > peak_z) peak_z = t;
    r.ox = peak_x[OFS_BITS-1:0];
    r.oy = peak_y[OFS_BITS-1:0];
    r.oz = peak_z[OFS_BITS-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < REPORT_LIMIT) $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic signed [OFS_BITS-1:0] got,
                             input logic signed [OFS_BITS-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  always @(posedge clk) begin : watch
    rotated_point_t want;
    if (!rst_n) begin
      expected_points.delete();
      ang_x   = '0;
      ang_y   = '0;
      ang_z   = '0;
      start_x = '0;
      start_y = '0;
      start_z = '0;
      peak_x  = 0;
      peak_y  = 0;
      peak_z  = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          report_mismatch($sformatf("result (%0d, %0d, %0d) with no point in flight",
                                    out_x, out_y, out_z));
        end else begin
          want = expected_points.pop_front();
          check_field("out_x", out_x, want.x);
          check_field("out_y", out_y, want.y);
          check_field("out_z", out_z, want.z);
          check_field("offset_x", offset_x, want.ox);
          check_field("offset_y", offset_y, want.oy);
          check_field("offset_z", offset_z, want.oz);
        end
      end
      if (in_valid && in_ready) expected_points.push_back(rotate_point(in_x, in_y, in_z));
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          REG_ANGLE_X: ang_x = cfg_data[ANGLE_W-1:0];
          REG_ANGLE_Y: ang_y = cfg_data[ANGLE_W-1:0];
          REG_ANGLE_Z: ang_z = cfg_data[ANGLE_W-1:0];
          REG_START_X: start_x = cfg_data[START_W-1:0];
          REG_START_Y: start_y = cfg_data[START_W-1:0];
          REG_START_Z: start_z = cfg_data[START_W-1:0];
          default: ;
        endcase
      end
    end
    outstanding <= expected_points.size();
  end

endmodule

FILE: sim/euler_point_rotation_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// euler_point_rotation_top_test
// Drives the point and register channels of the rotator with a short directed
// set and then randomly configured phases of random points, with random gaps
// and stalls on both sides; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module euler_point_rotation_top_test import epr_pkg::*;;

  localparam int COORD_BITS    = COORD_BITS_DEF;
  localparam int BLOCK_LATENCY = 22;
  localparam int RANDOM_POINTS = 1640;
  localparam int LONG_HOLD     = 300;
  localparam int CYCLE_LIMIT   = 1000000;

  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic signed [START_W-1:0]    S_MAX = {1'b0, {(START_W-1){1'b1}}};
  localparam logic signed [START_W-1:0]    S_MIN = {1'b1, {(START_W-1){1'b0}}};
  localparam logic [ANGLE_W-1:0]           A_TOP = {ANGLE_W{1'b1}};

  logic clk;
  logic rst_n;
  int   outstanding;
  int   mismatches;
  int   cycle_cnt;
  bit   src_gappy;
  bit   sink_gappy;
  int   long_hold_reqs;

  epr_in_if  #(.COORD_BITS(COORD_BITS)) in_pt ();
  epr_out_if #(.COORD_BITS(COORD_BITS)) out_pt ();
  epr_cfg_if                            cfg_wr ();

  euler_point_rotation_top #(.COORD_BITS(COORD_BITS)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_pt  (in_pt),
    .out_pt (out_pt),
    .cfg_wr (cfg_wr)
  );

  epr_rotation_checker #(.COORD_BITS(COORD_BITS)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_pt.valid),
    .in_ready    (in_pt.ready),
    .in_x        (in_pt.in_x),
    .in_y        (in_pt.in_y),
    .in_z        (in_pt.in_z),
    .out_valid   (out_pt.valid),
    .out_ready   (out_pt.ready),
    .out_x       (out_pt.out_x),
    .out_y       (out_pt.out_y),
    .out_z       (out_pt.out_z),
    .offset_x    (out_pt.offset_x),
    .offset_y    (out_pt.offset_y),
    .offset_z    (out_pt.offset_z),
    .cfg_valid   (cfg_wr.valid),
    .cfg_ready   (cfg_wr.ready),
    .cfg_addr    (cfg_wr.addr),
    .cfg_data    (cfg_wr.data),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("euler_point_rotation_top regression: fail");
      $finish;
    end
  end

  // mostly short, now and then long
  function automatic int idle_len();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 80) return $urandom_range(3, 1);
    else if (k < 95) return $urandom_range(10, 4);
    else return $urandom_range(40, 20);
  endfunction

  function automatic logic signed [COORD_BITS-1:0] pick_coord();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 10) begin
      case ($urandom_range(4))
        0: return C_MAX;
        1: return C_MIN;
        2: return '0;
        3: return '1;
        default: return COORD_BITS'(1);
      endcase
    end else if (k < 30) begin
      return COORD_BITS'($urandom_range(400) - 200);
    end
    return COORD_BITS'($urandom);
  endfunction

  function automatic logic [ANGLE_W-1:0] pick_angle();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 10) return ANGLE_W'(90 * $urandom_range(4));
    else if (k < 16) return ANGLE_W'($urandom_range(A_TOP, 360));
    else if (k < 20) return ANGLE_W'(359);
    return ANGLE_W'($urandom_range(359));
  endfunction

  function automatic logic signed [START_W-1:0] pick_start();
    case ($urandom_range(9))
      0: return S_MAX;
      1: return S_MIN;
      2: return '0;
      default: return START_W'($urandom);
    endcase
  endfunction

  task automatic send_point(input logic signed [COORD_BITS-1:0] px,
                            input logic signed [COORD_BITS-1:0] py,
                            input logic signed [COORD_BITS-1:0] pz);
    in_pt.valid <= 1'b1;
    in_pt.in_x  <= px;
    in_pt.in_y  <= py;
    in_pt.in_z  <= pz;
    @(posedge clk);
    while (!in_pt.ready) @(posedge clk);
  endtask

  task automatic idle_in(input int n);
    in_pt.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // sender stops until every point in flight has come back
  task automatic wait_drain();
    in_pt.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic reg_write(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_wr.valid <= 1'b1;
    cfg_wr.addr  <= idx;
    cfg_wr.data  <= val;
    @(posedge clk);
    while (!cfg_wr.ready) @(posedge clk);
  endtask

  task automatic program_regs(input logic [ANGLE_W-1:0] ax, input logic [ANGLE_W-1:0] ay,
                              input logic [ANGLE_W-1:0] az,
                              input logic signed [START_W-1:0] sx,
                              input logic signed [START_W-1:0] sy,
                              input logic signed [START_W-1:0] sz, input bit spare);
    logic [CFG_DATA_W-1:0] word;
    // junk in the bits above the angle field
    word = CFG_DATA_W'($urandom);
    word[ANGLE_W-1:0] = ax;
    reg_write(REG_ANGLE_X, word);
    word = CFG_DATA_W'($urandom);
    word[ANGLE_W-1:0] = ay;
    reg_write(REG_ANGLE_Y, word);
    word = CFG_DATA_W'($urandom);
    word[ANGLE_W-1:0] = az;
    reg_write(REG_ANGLE_Z, word);
    reg_write(REG_START_X, sx);
    reg_write(REG_START_Y, sy);
    reg_write(REG_START_Z, sz);
    if (spare) begin
      reg_write(REG_SPARE_LO, CFG_DATA_W'($urandom));
      reg_write(REG_SPARE_HI, CFG_DATA_W'($urandom));
    end
    cfg_wr.valid <= 1'b0;
  endtask

  initial begin : result_sink
    int stall_left;
    int held;
    int holds_done;
    stall_left = 0;
    holds_done = 0;
    out_pt.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_reqs != holds_done) begin
        out_pt.ready <= 1'b0;
        for (held = 0; held < LONG_HOLD; held++) @(posedge clk);
        holds_done++;
      end else if (stall_left > 0) begin
        out_pt.ready <= 1'b0;
        stall_left--;
      end else if (sink_gappy && $urandom_range(3) == 0) begin
        out_pt.ready <= 1'b0;
        stall_left = idle_len() - 1;
      end else begin
        out_pt.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int sent;
    int phase;
    int n;
    in_pt.valid  <= 1'b0;
    in_pt.in_x   <= '0;
    in_pt.in_y   <= '0;
    in_pt.in_z   <= '0;
    cfg_wr.valid <= 1'b0;
    cfg_wr.addr  <= '0;
    cfg_wr.data  <= '0;
    rst_n        <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: no rotation, start at origin
    send_point(0, 0, 0);
    send_point(C_MAX, C_MAX, C_MAX);
    send_point(C_MIN, C_MIN, C_MIN);
    send_point(-1, 1, -1);
    // quarter turns with extreme starts on x and y
    wait_drain();
    program_regs(90, 180, 270, S_MIN, S_MAX, -1, 1'b0);
    send_point(C_MAX, C_MIN, 12345);
    send_point(C_MIN, C_MAX, -1);
    send_point(1, -1, 0);
    // angles up to and past a full turn, writes to unused indices
    wait_drain();
    program_regs(A_TOP, 360, 359, S_MAX, S_MIN, 0, 1'b1);
    send_point(1000, -2000, 3000);
    send_point(C_MIN, C_MIN, C_MAX);
    // diagonal rotation drives coordinates into saturation
    wait_drain();
    program_regs(45, 45, 45, S_MIN, S_MIN, S_MIN, 1'b0);
    send_point(C_MAX, C_MAX, C_MAX);
    send_point(C_MIN, C_MIN, C_MIN);
    send_point(C_MAX, C_MIN, C_MAX);
    send_point(C_MIN, 0, C_MAX);
    wait_drain();
    program_regs(30, 60, 135, 0, 0, 0, 1'b1);
    send_point(7, -7, 100);

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_POINTS) begin
      wait_drain();
      program_regs(pick_angle(), pick_angle(), pick_angle(),
                   pick_start(), pick_start(), pick_start(), $urandom_range(7) == 0);
      src_gappy  = $urandom_range(2) != 0;
      sink_gappy = $urandom_range(2) != 0;
      n = $urandom_range(160, 40);
      if (phase % 6 == 0) begin
        // result side held off while points keep coming
        src_gappy  = 1'b0;
        sink_gappy = 1'b0;
        long_hold_reqs++;
        if (n < 80) n = 80;
      end
      if (n > RANDOM_POINTS - sent) n = RANDOM_POINTS - sent;
      repeat (n) begin
        send_point(pick_coord(), pick_coord(), pick_coord());
        sent++;
        if ($urandom_range(120) == 0) wait_drain();
        else if (src_gappy && $urandom_range(2) == 0) idle_in(idle_len());
      end
      phase++;
    end

    wait_drain();
    repeat (2 * BLOCK_LATENCY) @(posedge clk);
    if (mismatches == 0) begin
      $display("euler_point_rotation_top regression: pass");
    end else begin
      $display("euler_point_rotation_top regression: fail");
    end
    $finish;
  end

endmodule
